// File: rtl/top_scoring_pairs_trainer_assert.svh
// Assertion macros used by the checker of the top scoring pairs trainer
`ifndef TOP_SCORING_PAIRS_TRAINER_ASSERT_SVH
`define TOP_SCORING_PAIRS_TRAINER_ASSERT_SVH

// same-cycle implication
`define TSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsp check failed");

// next-cycle implication
`define TSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsp check failed");

`endif

// File: rtl/tsp_pkg.sv
// Package with widths, limits, register indexes and types of the pairs trainer
`default_nettype none
package tsp_pkg;
  localparam int GENE_W      = 6;
  localparam int SAMP_W      = 6;
  localparam int VAL_W       = 32;
  localparam int DELTA_W     = 12;
  localparam int GAMMA_W     = 20;
  localparam int RANK_W      = 13;
  localparam int CNT_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;
  localparam int MAX_GENES   = 64;
  localparam int MAX_SAMPLES = 64;
  localparam int MAX_PAIRS   = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_GENE_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS1_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS2_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAIR_COUNT   = 2'd3;

  typedef struct packed {
    logic [GENE_W-1:0]         gi;
    logic [GENE_W-1:0]         gj;
    logic signed [DELTA_W-1:0] delta;
    logic [GAMMA_W-1:0]        gamma;
  } pair_t;
endpackage
`default_nettype wire

// File: rtl/tsp_ram.sv
// Generic RAM with one write port and two registered read ports
`default_nettype none
module tsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule
`default_nettype wire

// File: rtl/top_scoring_pairs_trainer.sv
// Top level: top scoring pairs trainer with a sequencer over one shared datapath
// A load transaction writes one value and the sample's exclude flag. A start clears the rank sums,
// then scores every ordered gene pair over the samples (two value reads per sample),
// then per selected pair scans every candidate pair and skips used slots (one multiplier).
// in_ready is low from a start until the run ends, after its last result transaction if there is one.
// Synchronous active-low reset restores the register defaults and clears exclude flags.
`default_nettype none
module top_scoring_pairs_trainer (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     in_valid,
  output logic                                          in_ready,
  input  wire logic                                     in_req_type,
  input  wire logic [tsp_pkg::SAMP_W-1:0]               in_sample_index,
  input  wire logic [tsp_pkg::GENE_W-1:0]               in_gene_index,
  input  wire logic signed [tsp_pkg::VAL_W-1:0]         in_sample_value,
  input  wire logic                                     in_sample_excluded,
  output logic                                          out_valid,
  input  wire logic                                     out_ready,
  output logic [tsp_pkg::GENE_W-1:0]                    out_gene_first,
  output logic [tsp_pkg::GENE_W-1:0]                    out_gene_second,
  output logic signed [tsp_pkg::DELTA_W-1:0]            out_score_delta,
  output logic [tsp_pkg::GAMMA_W-1:0]                   out_score_gamma,
  output logic                                          out_last_pair,
  input  wire logic                                     cfg_valid,
  output logic                                          cfg_ready,
  input  wire logic [tsp_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  wire logic [tsp_pkg::CFG_DATA_W-1:0]           cfg_data
);
  localparam int GW = tsp_pkg::GENE_W;
  localparam int SW = tsp_pkg::SAMP_W;
  localparam int CW = tsp_pkg::CNT_W;
  localparam int RW = tsp_pkg::RANK_W;
  localparam int DW = tsp_pkg::DELTA_W;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CLR   = 5'd1;
  localparam logic [4:0] S_ROWRD = 5'd2;
  localparam logic [4:0] S_ROWLD = 5'd3;
  localparam logic [4:0] S_PAIR  = 5'd4;
  localparam logic [4:0] S_PJRD  = 5'd5;
  localparam logic [4:0] S_SMP   = 5'd6;
  localparam logic [4:0] S_PWR   = 5'd7;
  localparam logic [4:0] S_ROWWR = 5'd8;
  localparam logic [4:0] S_SINIT = 5'd9;
  localparam logic [4:0] S_RND   = 5'd10;
  localparam logic [4:0] S_SCAN  = 5'd11;
  localparam logic [4:0] S_G1    = 5'd12;
  localparam logic [4:0] S_G2    = 5'd13;
  localparam logic [4:0] S_G3    = 5'd14;
  localparam logic [4:0] S_G4    = 5'd15;
  localparam logic [4:0] S_REND  = 5'd16;
  localparam logic [4:0] S_OUT   = 5'd17;

  localparam logic [1:0] GO_RND  = 2'd0;
  localparam logic [1:0] GO_TAIL = 2'd1;
  localparam logic [1:0] GO_IDLE = 2'd2;

  logic [4:0]    state_r;
  logic [1:0]    next_r;
  logic [CW-1:0] gene_count_r;
  logic [SW-1:0] class1_count_r, class2_count_r;
  logic [4:0]    pair_count_r;
  logic [tsp_pkg::MAX_SAMPLES-1:0] excl_r;
  logic [tsp_pkg::MAX_GENES-1:0]   used_r;
  logic [SW-1:0] t_r, c1sz_r, c2sz_r;
  logic [CW-1:0] i_r, j_r, s_r;
  logic [4:0]    c_r;
  logic          pv_r, pcls1_r, pinc_r;
  logic signed [13:0] d_r, dl1_r, dl2_r;
  logic [RW-1:0] acc1_r, acc2_r, rj1_r, rj2_r;
  logic signed [DW-1:0] cd_r;
  logic signed [20:0] p_r, q_r;
  logic          found_r, pend_v_r;
  tsp_pkg::pair_t best_r, pend_r, out_r;
  logic          last_r;

  logic [CW-1:0] n_c, room_c, s2_c, total_c;
  logic [4:0]    k_c;
  logic          val_we;
  logic [tsp_pkg::VAL_W-1:0] va, vb;
  logic          rk_we;
  logic [GW-1:0] rk_waddr;
  logic [2*RW-1:0] rk_wdata, rk_ra, rk_rb;
  logic signed [DW-1:0] dsat, dl_rd;
  logic          below;
  logic [5:0]    mul_a;
  logic signed [13:0] mul_b;
  logic signed [20:0] mul_res;
  logic signed [21:0] gdiff, gabs;
  logic [tsp_pkg::GAMMA_W-1:0] gval;
  logic          better;

  assign n_c     = (gene_count_r > CW'(tsp_pkg::MAX_GENES)) ? CW'(tsp_pkg::MAX_GENES)
                                                            : gene_count_r;
  assign room_c  = CW'(tsp_pkg::MAX_SAMPLES) - {1'b0, class1_count_r};
  assign s2_c    = ({1'b0, class2_count_r} < room_c) ? {1'b0, class2_count_r} : room_c;
  assign total_c = {1'b0, class1_count_r} + s2_c;
  assign k_c     = (pair_count_r > 5'(tsp_pkg::MAX_PAIRS)) ? 5'(tsp_pkg::MAX_PAIRS)
                                                           : pair_count_r;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state_r == S_OUT);
  assign out_gene_first  = out_r.gi;
  assign out_gene_second = out_r.gj;
  assign out_score_delta = out_r.delta;
  assign out_score_gamma = out_r.gamma;
  assign out_last_pair   = last_r;

  assign val_we = in_valid && in_ready && !in_req_type;

  tsp_ram #(.WIDTH(tsp_pkg::VAL_W), .DEPTH(tsp_pkg::MAX_SAMPLES * tsp_pkg::MAX_GENES)) u_val (
    .clk     (clk),
    .we      (val_we),
    .waddr   ({in_sample_index, in_gene_index}),
    .wdata   (in_sample_value),
    .raddr_a ({s_r[SW-1:0], i_r[GW-1:0]}),
    .rdata_a (va),
    .raddr_b ({s_r[SW-1:0], j_r[GW-1:0]}),
    .rdata_b (vb)
  );

  assign rk_we    = (state_r == S_CLR) || (state_r == S_PWR) || (state_r == S_ROWWR);
  assign rk_waddr = (state_r == S_CLR) ? t_r :
                    (state_r == S_PWR) ? j_r[GW-1:0] : i_r[GW-1:0];
  assign rk_wdata = (state_r == S_CLR) ? '0 :
                    (state_r == S_PWR) ? {rj1_r, rj2_r} : {acc1_r, acc2_r};

  tsp_ram #(.WIDTH(2 * RW), .DEPTH(tsp_pkg::MAX_GENES)) u_rank (
    .clk     (clk),
    .we      (rk_we),
    .waddr   (rk_waddr),
    .wdata   (rk_wdata),
    .raddr_a (i_r[GW-1:0]),
    .rdata_a (rk_ra),
    .raddr_b (j_r[GW-1:0]),
    .rdata_b (rk_rb)
  );

  assign dsat = (d_r > 14'sd2047)  ? 12'sd2047 :
                (d_r < -14'sd2048) ? -12'sd2048 : d_r[DW-1:0];

  tsp_ram #(.WIDTH(DW), .DEPTH(tsp_pkg::MAX_GENES * tsp_pkg::MAX_GENES)) u_delta (
    .clk     (clk),
    .we      (state_r == S_PWR),
    .waddr   ({i_r[GW-1:0], j_r[GW-1:0]}),
    .wdata   (dsat),
    .raddr_a ({i_r[GW-1:0], j_r[GW-1:0]}),
    .rdata_a (dl_rd),
    .raddr_b ({i_r[GW-1:0], j_r[GW-1:0]}),
    .rdata_b ()
  );

  assign below   = $signed(va) < $signed(vb);
  assign mul_a   = (state_r == S_G2) ? c2sz_r : c1sz_r;
  assign mul_b   = (state_r == S_G2) ? dl1_r : dl2_r;
  assign mul_res = $signed({1'b0, mul_a}) * mul_b;
  assign gdiff   = {p_r[20], p_r} - {q_r[20], q_r};
  assign gabs    = gdiff[21] ? -gdiff : gdiff;
  assign gval    = (gabs > 22'sh0FFFFF) ? '1 : gabs[19:0];
  assign better  = !found_r || (cd_r > best_r.delta) ||
                   ((cd_r == best_r.delta) && (gval > best_r.gamma));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      gene_count_r   <= 7'd64;
      class1_count_r <= 6'd32;
      class2_count_r <= 6'd32;
      pair_count_r   <= 5'd1;
      excl_r         <= '0;
      used_r         <= '0;
      pend_v_r       <= 1'b0;
      found_r        <= 1'b0;
      pv_r           <= 1'b0;
      next_r         <= GO_IDLE;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          tsp_pkg::CFG_GENE_COUNT:   gene_count_r   <= cfg_data;
          tsp_pkg::CFG_CLASS1_COUNT: class1_count_r <= cfg_data[SW-1:0];
          tsp_pkg::CFG_CLASS2_COUNT: class2_count_r <= cfg_data[SW-1:0];
          tsp_pkg::CFG_PAIR_COUNT:   pair_count_r   <= cfg_data[4:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_req_type) begin
              t_r     <= '0;
              c1sz_r  <= '0;
              c2sz_r  <= '0;
              state_r <= S_CLR;
            end else begin
              excl_r[in_sample_index] <= in_sample_excluded;
            end
          end
        end
        S_CLR: begin
          if (({1'b0, t_r} < total_c) && !excl_r[t_r]) begin
            if (t_r < class1_count_r) c1sz_r <= c1sz_r + 6'd1;
            else c2sz_r <= c2sz_r + 6'd1;
          end
          t_r <= t_r + 6'd1;
          if (t_r == '1) begin
            i_r     <= '0;
            state_r <= S_ROWRD;
          end
        end
        S_ROWRD: begin
          state_r <= (i_r >= n_c) ? S_SINIT : S_ROWLD;
        end
        S_ROWLD: begin
          acc1_r  <= rk_ra[2*RW-1:RW];
          acc2_r  <= rk_ra[RW-1:0];
          j_r     <= '0;
          state_r <= S_PAIR;
        end
        S_PAIR: begin
          if (j_r >= n_c) begin
            state_r <= S_ROWWR;
          end else if (j_r == i_r) begin
            j_r <= j_r + 7'd1;
          end else begin
            d_r     <= '0;
            s_r     <= '0;
            state_r <= S_PJRD;
          end
        end
        S_PJRD: begin
          rj1_r   <= rk_rb[2*RW-1:RW];
          rj2_r   <= rk_rb[RW-1:0];
          pv_r    <= 1'b0;
          state_r <= S_SMP;
        end
        S_SMP: begin
          if (pv_r && pinc_r) begin
            if (pcls1_r) begin
              if (below) begin
                d_r   <= d_r + $signed({8'b0, c2sz_r});
                rj1_r <= rj1_r + 13'd1;
              end else begin
                acc1_r <= acc1_r + 13'd1;
              end
            end else begin
              if (below) begin
                d_r   <= d_r - $signed({8'b0, c1sz_r});
                rj2_r <= rj2_r + 13'd1;
              end else begin
                acc2_r <= acc2_r + 13'd1;
              end
            end
          end
          if (s_r < total_c) begin
            pv_r    <= 1'b1;
            pcls1_r <= s_r < {1'b0, class1_count_r};
            pinc_r  <= !excl_r[s_r[SW-1:0]];
            s_r     <= s_r + 7'd1;
          end else begin
            pv_r <= 1'b0;
            if (!pv_r) state_r <= S_PWR;
          end
        end
        S_PWR: begin
          j_r     <= j_r + 7'd1;
          state_r <= S_PAIR;
        end
        S_ROWWR: begin
          i_r     <= i_r + 7'd1;
          state_r <= S_ROWRD;
        end
        S_SINIT: begin
          c_r      <= '0;
          pend_v_r <= 1'b0;
          used_r   <= '0;
          state_r  <= (k_c == '0) ? S_IDLE : S_RND;
        end
        S_RND: begin
          found_r <= 1'b0;
          i_r     <= '0;
          j_r     <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (i_r >= n_c) begin
            state_r <= S_REND;
          end else if ((j_r >= n_c) || used_r[i_r[GW-1:0]]) begin
            i_r <= i_r + 7'd1;
            j_r <= '0;
          end else if ((j_r == i_r) || used_r[j_r[GW-1:0]]) begin
            j_r <= j_r + 7'd1;
          end else begin
            state_r <= S_G1;
          end
        end
        S_G1: begin
          dl1_r   <= $signed({1'b0, rk_ra[2*RW-1:RW]}) - $signed({1'b0, rk_rb[2*RW-1:RW]});
          dl2_r   <= $signed({1'b0, rk_ra[RW-1:0]}) - $signed({1'b0, rk_rb[RW-1:0]});
          cd_r    <= dl_rd;
          state_r <= S_G2;
        end
        S_G2: begin
          p_r     <= mul_res;
          state_r <= S_G3;
        end
        S_G3: begin
          q_r     <= mul_res;
          state_r <= S_G4;
        end
        S_G4: begin
          if (better) begin
            found_r      <= 1'b1;
            best_r.gi    <= i_r[GW-1:0];
            best_r.gj    <= j_r[GW-1:0];
            best_r.delta <= cd_r;
            best_r.gamma <= gval;
          end
          j_r     <= j_r + 7'd1;
          state_r <= S_SCAN;
        end
        S_REND: begin
          if (found_r) begin
            used_r[best_r.gi] <= 1'b1;
            used_r[best_r.gj] <= 1'b1;
            pend_r   <= best_r;
            pend_v_r <= 1'b1;
            c_r      <= c_r + 5'd1;
            if (pend_v_r) begin
              out_r   <= pend_r;
              last_r  <= 1'b0;
              next_r  <= (c_r + 5'd1 == k_c) ? GO_TAIL : GO_RND;
              state_r <= S_OUT;
            end else if (c_r + 5'd1 == k_c) begin
              out_r   <= best_r;
              last_r  <= 1'b1;
              next_r  <= GO_IDLE;
              state_r <= S_OUT;
            end else begin
              state_r <= S_RND;
            end
          end else if (pend_v_r) begin
            out_r   <= pend_r;
            last_r  <= 1'b1;
            next_r  <= GO_IDLE;
            state_r <= S_OUT;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            case (next_r)
              GO_TAIL: begin
                out_r  <= pend_r;
                last_r <= 1'b1;
                next_r <= GO_IDLE;
              end
              GO_RND:  state_r <= S_RND;
              default: state_r <= S_IDLE;
            endcase
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/tsp_checker.sv
// Port-level checker for the pairs trainer and its bind to the top level
`default_nettype none
`include "top_scoring_pairs_trainer_assert.svh"
module tsp_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [tsp_pkg::GENE_W-1:0]  out_gene_first,
  input wire logic [tsp_pkg::GENE_W-1:0]  out_gene_second,
  input wire logic                        out_last_pair
);
  `TSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_gene_first))
  `TSP_ASSERT_NOW(a_busy_out, out_valid, !in_ready)
  `TSP_ASSERT_NOW(a_pair_distinct, out_valid, out_gene_first != out_gene_second)
  `TSP_ASSERT_NEXT(a_more_follow, out_valid && out_ready && !out_last_pair, !in_ready)
endmodule

bind top_scoring_pairs_trainer tsp_checker u_tsp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_gene_first  (out_gene_first),
  .out_gene_second (out_gene_second),
  .out_last_pair   (out_last_pair)
);
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the top scoring pairs trainer with its own pair scoring predictor
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tsp_pkg::*;

  localparam int QUIET_LIMIT = 300000;
  localparam int HOLD_CYCLES = 600;
  localparam int SETTLE_CYCLES = 200;

  typedef struct {
    pair_t pair;
    logic  last;
  } pair_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_req_type = 1'b0;
  logic [SAMP_W-1:0] in_sample_index = '0;
  logic [GENE_W-1:0] in_gene_index = '0;
  logic signed [VAL_W-1:0] in_sample_value = '0;
  logic in_sample_excluded = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [GENE_W-1:0] out_gene_first;
  logic [GENE_W-1:0] out_gene_second;
  logic signed [DELTA_W-1:0] out_score_delta;
  logic [GAMMA_W-1:0] out_score_gamma;
  logic out_last_pair;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  top_scoring_pairs_trainer dut (.*);

  always #6 clk = ~clk;

  // predictor state
  longint expr_values [MAX_SAMPLES][MAX_GENES];
  bit     written     [MAX_SAMPLES][MAX_GENES];
  bit     excl_flags  [MAX_SAMPLES];
  int     rank1       [MAX_GENES];
  int     rank2       [MAX_GENES];
  int     pair_delta  [MAX_GENES][MAX_GENES];
  bit     gene_taken  [MAX_GENES];
  int     size1, size2;
  int     reg_genes = 64, reg_class1 = 32, reg_class2 = 32, reg_pairs = 1;

  pair_result_t expected_pairs[$];
  pair_result_t head;
  int errors = 0;
  int items_sent = 0;
  int quiet = 0;
  bit calm = 1'b0;
  bit hold_long = 1'b0;

  function automatic longint pair_gamma(int i, int j);
    longint g;
    g = longint'(size2) * (rank1[i] - rank1[j]) - longint'(size1) * (rank2[i] - rank2[j]);
    if (g < 0) g = -g;
    if (g > 64'hFFFFF) g = 64'hFFFFF;
    return g;
  endfunction

  function automatic void predict_training();
    int n, s1, s2, k, i, j, s, c, bi, bj, emitted;
    longint d, bd, bg, g;
    bit found, below;
    pair_result_t r;
    n = reg_genes < MAX_GENES ? reg_genes : MAX_GENES;
    s1 = reg_class1 < MAX_SAMPLES ? reg_class1 : MAX_SAMPLES;
    s2 = reg_class2 < MAX_SAMPLES - s1 ? reg_class2 : MAX_SAMPLES - s1;
    k = reg_pairs < MAX_PAIRS ? reg_pairs : MAX_PAIRS;
    emitted = 0;
    size1 = 0;
    size2 = 0;
    for (i = 0; i < MAX_GENES; i++) begin
      rank1[i] = 0;
      rank2[i] = 0;
      gene_taken[i] = 0;
    end
    for (s = 0; s < s1 + s2; s++)
      if (!excl_flags[s]) begin
        if (s < s1) size1++;
        else size2++;
      end
    for (i = 0; i < n; i++)
      for (j = 0; j < n; j++) begin
        if (i == j) continue;
        d = 0;
        for (s = 0; s < s1 + s2; s++) begin
          if (excl_flags[s]) continue;
          below = expr_values[s][i] < expr_values[s][j];
          if (s < s1) begin
            if (below) begin
              d += size2;
              rank1[j]++;
            end else rank1[i]++;
          end else begin
            if (below) begin
              d -= size1;
              rank2[j]++;
            end else rank2[i]++;
          end
        end
        if (d > 2047) d = 2047;
        if (d < -2048) d = -2048;
        pair_delta[i][j] = int'(d);
      end
    for (c = 0; c < k; c++) begin
      found = 0;
      bi = 0;
      bj = 0;
      bd = 0;
      bg = 0;
      for (i = 0; i < n; i++) begin
        if (gene_taken[i]) continue;
        for (j = 0; j < n; j++) begin
          if (i == j || gene_taken[j]) continue;
          d = pair_delta[i][j];
          g = pair_gamma(i, j);
          if (!found || d > bd || (d == bd && g > bg)) begin
            found = 1;
            bi = i;
            bj = j;
            bd = d;
            bg = g;
          end
        end
      end
      if (!found) break;
      gene_taken[bi] = 1;
      gene_taken[bj] = 1;
      r.pair.gi = bi[GENE_W-1:0];
      r.pair.gj = bj[GENE_W-1:0];
      r.pair.delta = bd[DELTA_W-1:0];
      r.pair.gamma = bg[GAMMA_W-1:0];
      r.last = 1'b0;
      expected_pairs = {expected_pairs, r};
      emitted++;
    end
    if (emitted > 0) expected_pairs[expected_pairs.size()-1].last = 1'b1;
  endfunction

  function automatic logic [VAL_W-1:0] draw_value();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(0, 6)) - 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(input logic rt, input int sidx, input int gidx,
                           input logic [VAL_W-1:0] val, input logic ex);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req_type <= rt;
    in_sample_index <= sidx[SAMP_W-1:0];
    in_gene_index <= gidx[GENE_W-1:0];
    in_sample_value <= val;
    in_sample_excluded <= ex;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (rt) predict_training();
    else begin
      expr_values[sidx][gidx] = longint'($signed(val));
      written[sidx][gidx] = 1'b1;
      excl_flags[sidx] = ex;
    end
  endtask

  task automatic load(input int sidx, input int gidx, input logic [VAL_W-1:0] val,
                      input logic ex);
    send_item(1'b0, sidx, gidx, val, ex);
  endtask

  task automatic start_training();
    send_item(1'b1, $urandom_range(0, 63), $urandom_range(0, 63), $urandom, $urandom_range(0, 1));
  endtask

  // write every entry the next start will read that has never been loaded
  task automatic fill_table();
    int n, s1, s2, s, g;
    n = reg_genes < MAX_GENES ? reg_genes : MAX_GENES;
    s1 = reg_class1;
    s2 = reg_class2 < MAX_SAMPLES - s1 ? reg_class2 : MAX_SAMPLES - s1;
    for (s = 0; s < s1 + s2; s++)
      for (g = 0; g < n; g++)
        if (!written[s][g]) load(s, g, draw_value(), $urandom_range(0, 5) == 0);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_index <= idx;
    cfg_data <= data[CFG_DATA_W-1:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_GENE_COUNT:   reg_genes = data & 8'h7F;
      CFG_CLASS1_COUNT: reg_class1 = data & 8'h3F;
      CFG_CLASS2_COUNT: reg_class2 = data & 8'h3F;
      default:          reg_pairs = data & 8'h1F;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(input int genes, input int c1, input int c2, input int pairs);
    wait_idle();
    write_reg(CFG_GENE_COUNT, genes);
    write_reg(CFG_CLASS1_COUNT, c1);
    write_reg(CFG_CLASS2_COUNT, c2);
    write_reg(CFG_PAIR_COUNT, pairs);
  endtask

  task automatic test_small_corners();
    int g;
    configure(2, 1, 1, 1);
    load(0, 0, 32'h8000_0000, 1'b0);
    load(0, 1, 32'h7FFF_FFFF, 1'b0);
    load(1, 0, 32'h7FFF_FFFF, 1'b0);
    load(1, 1, 32'h8000_0000, 1'b0);
    start_training();
    configure(4, 2, 2, 31);
    for (g = 0; g < 4; g++) load(0, g, 32'd5, 1'b0);
    fill_table();
    load(3, 2, 32'hFFFF_0000, 1'b1);
    start_training();
    configure(1, 2, 2, 3);
    start_training();
    configure(0, 2, 2, 3);
    start_training();
    configure(4, 2, 2, 0);
    start_training();
    load(63, 63, draw_value(), 1'b0);
    load(42, 21, draw_value(), 1'b1);
  endtask

  task automatic test_size_extremes();
    configure(2, 63, 63, 2);
    fill_table();
    start_training();
    configure(127, 1, 1, 1);
    fill_table();
    start_training();
    configure(33, 1, 1, 16);
    start_training();
  endtask

  task automatic test_output_pressure();
    int i;
    configure(8, 3, 3, 4);
    fill_table();
    hold_long = 1'b1;
    start_training();
    for (i = 0; i < 6; i++) load($urandom_range(0, 5), $urandom_range(0, 7), draw_value(), 1'b0);
    start_training();
  endtask

  task automatic test_random_training();
    int n, s1, s2, k, i, cnt;
    while (items_sent < 320) begin
      n = $urandom_range(2, 8);
      s1 = $urandom_range(1, 6);
      s2 = $urandom_range(1, 6);
      k = $urandom_range(0, 9) == 0 ? $urandom_range(17, 31) : $urandom_range(0, 5);
      configure(n, s1, s2, k);
      calm = $urandom_range(0, 4) == 0;
      cnt = $urandom_range(3, 15);
      for (i = 0; i < cnt; i++)
        if ($urandom_range(0, 4) == 0)
          load($urandom_range(0, 63), $urandom_range(0, 63), draw_value(), $urandom_range(0, 1));
        else
          load($urandom_range(0, s1 + s2 - 1), $urandom_range(0, n - 1), draw_value(),
               $urandom_range(0, 4) == 0);
      fill_table();
      start_training();
      calm = 1'b0;
    end
  endtask

  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_long = 1'b0;
      end
      stall = calm ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_pairs.size() == 0) begin
        $display("%0t unexpected result pair %0d,%0d", $time, out_gene_first, out_gene_second);
        errors++;
      end else begin
        head = expected_pairs.pop_front();
        if (out_gene_first !== head.pair.gi) begin
          $display("%0t gene_first exp %0d got %0d", $time, head.pair.gi, out_gene_first);
          errors++;
        end
        if (out_gene_second !== head.pair.gj) begin
          $display("%0t gene_second exp %0d got %0d", $time, head.pair.gj, out_gene_second);
          errors++;
        end
        if (out_score_delta !== head.pair.delta) begin
          $display("%0t score_delta exp %0d got %0d", $time, head.pair.delta, out_score_delta);
          errors++;
        end
        if (out_score_gamma !== head.pair.gamma) begin
          $display("%0t score_gamma exp %0d got %0d", $time, head.pair.gamma, out_score_gamma);
          errors++;
        end
        if (out_last_pair !== head.last) begin
          $display("%0t last_pair exp %0d got %0d", $time, head.last, out_last_pair);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  initial begin
    foreach (excl_flags[s]) excl_flags[s] = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_small_corners();
    test_size_extremes();
    test_output_pressure();
    test_random_training();
    in_valid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end
endmodule
`default_nettype wire
